@@ hw/rtl/siis_pkg.sv @@
// ----------------------------------------------------------------------------
// siis_pkg
// Shared types, codes and index functions of the symmetric integral index
// store.
// ----------------------------------------------------------------------------
package siis_pkg;

    // Field widths of one transaction in each direction.
    localparam int ACT_W = 2;
    localparam int ORB_W = 3;
    localparam int VAL_W = 64;
    localparam int IDX_W = 10;
    localparam int ST_W  = 2;

    // A pair index over ORB_W-bit orbitals, and a compound index over pairs.
    localparam int PAIR_W = 2 * ORB_W;

    // Default orbital count.
    localparam int ORBITALS_DEF = 8;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_EXISTS = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SET    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_GET    = 2'd2;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_MISSING = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE   = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [ORB_W-1:0] orbital_a;
        logic [ORB_W-1:0] orbital_b;
        logic [ORB_W-1:0] orbital_c;
        logic [ORB_W-1:0] orbital_d;
        logic [VAL_W-1:0] write_value;
    } t_cmd;

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] read_value;
        logic [IDX_W-1:0] compound_index;
        logic [ST_W-1:0]  status;
    } t_result;

    // Resolved lookup handed from the index stages to the store.
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             out_of_range;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] write_value;
    } t_lookup;

    // Triangular pair index of two orbitals: max*(max+1)/2 + min.
    function automatic logic [PAIR_W-1:0] pair_index(
        input logic [ORB_W-1:0] x,
        input logic [ORB_W-1:0] y
    );
        logic [ORB_W-1:0]   hi;
        logic [ORB_W-1:0]   lo;
        logic [ORB_W:0]     hp1;
        logic [2*ORB_W:0]   prod;
        hi   = (x > y) ? x : y;
        lo   = (x > y) ? y : x;
        hp1  = {1'b0, hi} + 1'b1;
        prod = (2*ORB_W+1)'(hi) * (2*ORB_W+1)'(hp1);
        return PAIR_W'((prod >> 1) + (2*ORB_W+1)'(lo));
    endfunction

    // The same rule applied over two pair indices.
    function automatic logic [IDX_W-1:0] compound_of(
        input logic [PAIR_W-1:0] x,
        input logic [PAIR_W-1:0] y
    );
        logic [PAIR_W-1:0]  hi;
        logic [PAIR_W-1:0]  lo;
        logic [PAIR_W:0]    hp1;
        logic [2*PAIR_W:0]  prod;
        hi   = (x > y) ? x : y;
        lo   = (x > y) ? y : x;
        hp1  = {1'b0, hi} + 1'b1;
        prod = (2*PAIR_W+1)'(hi) * (2*PAIR_W+1)'(hp1);
        return IDX_W'((prod >> 1) + (2*PAIR_W+1)'(lo));
    endfunction

endpackage

@@ hw/rtl/siis_index.sv @@
// ----------------------------------------------------------------------------
// siis_index
// Two-stage index pipeline: pair indices first, then the compound index and
// the range check.
// ----------------------------------------------------------------------------
module siis_index
    import siis_pkg::*;
#(
    parameter int ORBITALS = ORBITALS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_cmd    i_cmd,
    output logic    o_valid,
    output t_lookup o_lookup
);

    localparam int PAIRS   = ORBITALS * (ORBITALS + 1) / 2;
    localparam int ENTRIES = PAIRS * (PAIRS + 1) / 2;

    logic              r_v1;
    logic [ACT_W-1:0]  r_act1;
    logic [VAL_W-1:0]  r_wv1;
    logic [PAIR_W-1:0] r_pab;
    logic [PAIR_W-1:0] r_pcd;
    logic              r_oor1;
    logic              n_oor1;
    logic [IDX_W-1:0]  n_idx;

    // Any orbital at or beyond the orbital count is out of range.
    always_comb begin
        n_oor1 = (32'(i_cmd.orbital_a) >= ORBITALS) || (32'(i_cmd.orbital_b) >= ORBITALS) ||
                 (32'(i_cmd.orbital_c) >= ORBITALS) || (32'(i_cmd.orbital_d) >= ORBITALS);
    end

    // Valid flags of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1    <= i_valid;
            o_valid <= r_v1;
        end
    end

    // First stage: the two pair indices.
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_act1 <= i_cmd.action;
            r_wv1  <= i_cmd.write_value;
            r_pab  <= pair_index(i_cmd.orbital_a, i_cmd.orbital_b);
            r_pcd  <= pair_index(i_cmd.orbital_c, i_cmd.orbital_d);
            r_oor1 <= n_oor1;
        end
    end

    assign n_idx = compound_of(r_pab, r_pcd);

    // Second stage: compound index, checked against the store depth.
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            o_lookup.action       <= r_act1;
            o_lookup.write_value  <= r_wv1;
            o_lookup.idx          <= n_idx;
            o_lookup.out_of_range <= r_oor1 || (32'(n_idx) >= ENTRIES);
        end
    end

endmodule

@@ hw/rtl/siis_store.sv @@
// ----------------------------------------------------------------------------
// siis_store
// Direct-addressed value store with a valid bit per entry, a clearing sweep
// after reset and a read-modify-write path that forms each result.
// ----------------------------------------------------------------------------
module siis_store
    import siis_pkg::*;
#(
    parameter int ORBITALS = ORBITALS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_lookup i_lookup,
    output logic    o_clearing,
    output logic    o_done,
    output t_result o_result
);

    localparam int PAIRS   = ORBITALS * (ORBITALS + 1) / 2;
    localparam int ENTRIES = PAIRS * (PAIRS + 1) / 2;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Each word holds the valid bit above the value.
    logic [VAL_W:0]   r_mem [ENTRIES];
    logic [VAL_W:0]   r_rd;
    logic             r_v;
    t_lookup          r_lk;
    logic             r_clearing;
    logic [AW-1:0]    r_clr_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [VAL_W:0]   wr_data;
    logic             held;
    t_result          n_result;

    // Clearing sweep: one entry a cycle from reset on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(ENTRIES - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_clearing = r_clearing;

    // Read stage: the lookup is held beside the registered read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_lk <= i_lookup;
            r_rd <= r_mem[AW'(i_lookup.idx)];
        end
    end

    // Write port: the sweep has priority; a set writes back in the result stage.
    always_comb begin
        held = r_rd[VAL_W] && !r_lk.out_of_range;
        if (r_clearing) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = r_v && !r_lk.out_of_range && (r_lk.action == ACT_SET);
            wr_addr = AW'(r_lk.idx);
            wr_data = {1'b1, r_lk.write_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // Result of the transaction from the entry as it stood before any write.
    always_comb begin
        n_result.found          = held;
        n_result.read_value     = '0;
        n_result.compound_index = r_lk.out_of_range ? '0 : r_lk.idx;
        n_result.status         = ST_OK;
        if (r_lk.out_of_range) begin
            n_result.status = ST_RANGE;
        end else if (r_lk.action == ACT_GET) begin
            if (held) begin
                n_result.read_value = r_rd[VAL_W-1:0];
            end else begin
                n_result.status = ST_MISSING;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v) begin
            o_result <= n_result;
        end
    end

endmodule

@@ hw/rtl/symmetric_integral_index_store.sv @@
// ----------------------------------------------------------------------------
// symmetric_integral_index_store
// Integral value store addressed by a symmetric compound index of four
// orbitals, with exists, set and get transactions.
// ----------------------------------------------------------------------------
// Usage:
// A command transaction is accepted at a rising edge where start is high and
// busy is low; i_cmd carries the action, four orbitals and the value to set.
// Each command gives exactly one result on o_result, shown for one cycle with
// o_done high. The receiver cannot stall; the result must be taken then.
// An accepted command passes the two multiply stages of the index pipeline,
// the registered read of the value memory and the result register, where a
// set also writes back. o_done rises with the result, and busy falls at the
// edge where the result is taken, so a new command is accepted only after the
// last one has given its result; only one command is in flight, so no two
// accesses to an entry ever overlap.
// After reset the block sweeps the memory to clear every valid bit, one entry
// a cycle, ORBITALS*(ORBITALS+1)/2 pairs giving P*(P+1)/2 entries (666 entries
// for eight orbitals); busy stays high throughout the sweep.
// ----------------------------------------------------------------------------
module symmetric_integral_index_store
    import siis_pkg::*;
#(
    parameter int ORBITALS = ORBITALS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cmd    i_cmd,
    output logic    o_done,
    output t_result o_result
);

    logic    accept;
    logic    r_pending;
    logic    lk_valid;
    t_lookup lookup;
    logic    clearing;

    assign accept = start && !busy;
    assign busy   = r_pending || clearing;

    // One command in flight, from acceptance to its result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else if (accept) begin
            r_pending <= 1'b1;
        end else if (o_done) begin
            r_pending <= 1'b0;
        end
    end

    siis_index #(
        .ORBITALS (ORBITALS)
    ) u_index (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_cmd    (i_cmd),
        .o_valid  (lk_valid),
        .o_lookup (lookup)
    );

    siis_store #(
        .ORBITALS (ORBITALS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (lk_valid),
        .i_lookup   (lookup),
        .o_clearing (clearing),
        .o_done     (o_done),
        .o_result   (o_result)
    );

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the symmetric integral index store. Commands go in
// through the start/busy handshake, and the one result of each is compared,
// field by field, with a prediction made when the command was accepted. A
// short directed table comes first. Random exists, set, get and spare commands then
// follow, mostly on orbital tuples already written, so that gets hit stored
// entries under every symmetric permutation of the four orbitals.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import siis_pkg::*;

    localparam int ORBITAL_COUNT = ORBITALS_DEF;
    localparam int PAIR_COUNT    = ORBITAL_COUNT * (ORBITAL_COUNT + 1) / 2;
    localparam int ENTRY_COUNT   = PAIR_COUNT * (PAIR_COUNT + 1) / 2;
    localparam int RANDOM_ITEMS  = 530;
    localparam int POOL_DEPTH    = 24;

    // The spare action code is answered as an exists query.
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    typedef struct {
        t_cmd    cmd;
        bit      typed;
        t_result res;
    } t_directed_row;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_cmd    i_cmd;
    logic    o_done;
    t_result o_result;

    // Predicted contents of the store.
    bit               entry_held [ENTRY_COUNT];
    logic [VAL_W-1:0] entry_word [ENTRY_COUNT];

    // Results still owed by the block, oldest first.
    t_result pending_results[$];
    // Orbital tuples that have been written, reused to hit stored entries.
    logic [4*ORB_W-1:0] written_tuples[$];
    t_directed_row directed_rows[$];
    int unsigned mismatches = 0;

    symmetric_integral_index_store u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Guard against a hung handshake.
    initial begin
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end

    // Triangular fold of two indices: max*(max+1)/2 + min.
    function automatic int unsigned tri_fold(input int unsigned x, input int unsigned y);
        int unsigned hi;
        int unsigned lo;
        hi = (x > y) ? x : y;
        lo = (x > y) ? y : x;
        return hi * (hi + 1) / 2 + lo;
    endfunction

    // Works out the result of one command and applies it to the predicted store.
    function automatic t_result store_lookup(input t_cmd c);
        t_result     r;
        int unsigned idx;
        r = '0;
        if (c.orbital_a >= ORBITAL_COUNT || c.orbital_b >= ORBITAL_COUNT ||
            c.orbital_c >= ORBITAL_COUNT || c.orbital_d >= ORBITAL_COUNT) begin
            r.status = ST_RANGE;
            return r;
        end
        idx = tri_fold(tri_fold(c.orbital_a, c.orbital_b),
                       tri_fold(c.orbital_c, c.orbital_d));
        if (idx >= ENTRY_COUNT) begin
            r.status = ST_RANGE;
            return r;
        end
        r.found          = entry_held[idx];
        r.compound_index = IDX_W'(idx);
        case (c.action)
            ACT_SET: begin
                entry_word[idx] = c.write_value;
                entry_held[idx] = 1'b1;
            end
            ACT_GET: begin
                if (r.found)
                    r.read_value = entry_word[idx];
                else
                    r.status = ST_MISSING;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_cmd cmd_of(
        input logic [ACT_W-1:0] act,
        input int unsigned a, input int unsigned b,
        input int unsigned c, input int unsigned d,
        input logic [VAL_W-1:0] value
    );
        t_cmd x;
        x.action      = act;
        x.orbital_a   = ORB_W'(a);
        x.orbital_b   = ORB_W'(b);
        x.orbital_c   = ORB_W'(c);
        x.orbital_d   = ORB_W'(d);
        x.write_value = value;
        return x;
    endfunction

    function automatic t_result res_of(
        input logic found, input logic [VAL_W-1:0] value,
        input int unsigned idx, input logic [ST_W-1:0] st
    );
        t_result x;
        x.found          = found;
        x.read_value     = value;
        x.compound_index = IDX_W'(idx);
        x.status         = st;
        return x;
    endfunction

    // Random command: mostly sets and gets, with orbitals often taken from a
    // tuple already written and shuffled through its symmetric permutations.
    function automatic t_cmd random_command();
        t_cmd               c;
        int unsigned        pick;
        logic [ORB_W-1:0]   t;
        logic [4*ORB_W-1:0] tuple;
        pick = $urandom_range(99);
        if (pick < 40)
            c.action = ACT_SET;
        else if (pick < 80)
            c.action = ACT_GET;
        else if (pick < 92)
            c.action = ACT_EXISTS;
        else
            c.action = ACT_SPARE;

        if (written_tuples.size() != 0 && $urandom_range(99) < 65) begin
            tuple = written_tuples[$urandom_range(written_tuples.size() - 1)];
            {c.orbital_a, c.orbital_b, c.orbital_c, c.orbital_d} = tuple;
            if ($urandom_range(1)) begin
                t = c.orbital_a; c.orbital_a = c.orbital_b; c.orbital_b = t;
            end
            if ($urandom_range(1)) begin
                t = c.orbital_c; c.orbital_c = c.orbital_d; c.orbital_d = t;
            end
            if ($urandom_range(1)) begin
                {c.orbital_a, c.orbital_b, c.orbital_c, c.orbital_d} =
                    {c.orbital_c, c.orbital_d, c.orbital_a, c.orbital_b};
            end
        end else begin
            c.orbital_a = ORB_W'($urandom);
            c.orbital_b = ORB_W'($urandom);
            c.orbital_c = ORB_W'($urandom);
            c.orbital_d = ORB_W'($urandom);
        end

        pick = $urandom_range(99);
        if (pick < 5)
            c.write_value = '0;
        else if (pick < 10)
            c.write_value = '1;
        else
            c.write_value = {$urandom, $urandom};

        if (c.action == ACT_SET) begin
            written_tuples.push_back({c.orbital_a, c.orbital_b, c.orbital_c, c.orbital_d});
            if (written_tuples.size() > POOL_DEPTH)
                void'(written_tuples.pop_front());
        end
        return c;
    endfunction

    // Presents one command and holds it until the block takes the transaction.
    task automatic issue(input t_cmd c, input bit typed, input t_result typed_res);
        t_result predicted;
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        predicted = store_lookup(c);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // Occasional gap between commands, with start held low.
    task automatic maybe_idle(input bit allowed);
        if (allowed && $urandom_range(99) < 14) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Holds the sender off until every owed result has come back.
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Result checker: each strobed result against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing expected: %p", o_result);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.found !== want.found) begin
                    $error("found: expected %0b, got %0b", want.found, o_result.found);
                    mismatches++;
                end
                if (o_result.read_value !== want.read_value) begin
                    $error("read_value: expected %h, got %h",
                           want.read_value, o_result.read_value);
                    mismatches++;
                end
                if (o_result.compound_index !== want.compound_index) begin
                    $error("compound_index: expected %0d, got %0d",
                           want.compound_index, o_result.compound_index);
                    mismatches++;
                end
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_result.status);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus.
    initial begin
        int unsigned n;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_cmd   <= '0;

        // Directed table. The corner tuple (7,7,7,7) folds to the top index 665.
        directed_rows.push_back('{cmd_of(ACT_EXISTS, 0, 0, 0, 0, '1), 1'b1,
                                  res_of(1'b0, '0, 0, ST_OK)});
        directed_rows.push_back('{cmd_of(ACT_GET, 0, 0, 0, 0, '0), 1'b1,
                                  res_of(1'b0, '0, 0, ST_MISSING)});
        directed_rows.push_back('{cmd_of(ACT_GET, 7, 7, 7, 7, '0), 1'b1,
                                  res_of(1'b0, '0, 665, ST_MISSING)});
        directed_rows.push_back('{cmd_of(ACT_SET, 7, 7, 7, 7, '1), 1'b1,
                                  res_of(1'b0, '0, 665, ST_OK)});
        directed_rows.push_back('{cmd_of(ACT_GET, 7, 7, 7, 7, '0), 1'b1,
                                  res_of(1'b1, '1, 665, ST_OK)});
        directed_rows.push_back('{cmd_of(ACT_SPARE, 7, 7, 7, 7, '1), 1'b1,
                                  res_of(1'b1, '0, 665, ST_OK)});
        directed_rows.push_back('{cmd_of(ACT_SET, 7, 7, 7, 7, '0), 1'b1,
                                  res_of(1'b1, '0, 665, ST_OK)});
        directed_rows.push_back('{cmd_of(ACT_GET, 7, 7, 7, 7, '1), 1'b1,
                                  res_of(1'b1, '0, 665, ST_OK)});
        directed_rows.push_back('{cmd_of(ACT_SET, 0, 0, 0, 0, 64'h5555_5555_5555_5555),
                                  1'b1, res_of(1'b0, '0, 0, ST_OK)});
        directed_rows.push_back('{cmd_of(ACT_GET, 0, 0, 0, 0, '0), 1'b1,
                                  res_of(1'b1, 64'h5555_5555_5555_5555, 0, ST_OK)});
        // Symmetric permutations must land on the same entry.
        directed_rows.push_back('{cmd_of(ACT_SET, 1, 2, 3, 4, 64'hA5A5_A5A5_A5A5_A5A5),
                                  1'b0, '0});
        directed_rows.push_back('{cmd_of(ACT_GET, 2, 1, 4, 3, '0), 1'b0, '0});
        directed_rows.push_back('{cmd_of(ACT_GET, 3, 4, 1, 2, '0), 1'b0, '0});
        directed_rows.push_back('{cmd_of(ACT_EXISTS, 4, 3, 2, 1, '0), 1'b0, '0});
        directed_rows.push_back('{cmd_of(ACT_SET, 7, 0, 0, 7, 64'h8000_0000_0000_0001),
                                  1'b0, '0});
        directed_rows.push_back('{cmd_of(ACT_GET, 0, 7, 7, 0, '0), 1'b0, '0});
        directed_rows.push_back('{cmd_of(ACT_SPARE, 5, 6, 6, 5, '0), 1'b0, '0});
        directed_rows.push_back('{cmd_of(ACT_GET, 6, 5, 6, 5, '0), 1'b0, '0});
        directed_rows.push_back('{cmd_of(ACT_SET, 6, 5, 5, 6, 64'h0123_4567_89AB_CDEF),
                                  1'b0, '0});
        directed_rows.push_back('{cmd_of(ACT_GET, 5, 6, 6, 5, '0), 1'b0, '0});
        directed_rows.push_back('{cmd_of(ACT_EXISTS, 7, 7, 7, 7, '0), 1'b1,
                                  res_of(1'b1, '0, 665, ST_OK)});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            issue(directed_rows[k].cmd, directed_rows[k].typed, directed_rows[k].res);
            maybe_idle(1'b1);
        end
        drain();

        // Random part, with a stretch of back-to-back commands in the middle.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2)
                drain();
            issue(random_command(), 1'b0, '0);
            maybe_idle(!(n >= 150 && n < 300));
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
